/* src/motor_soft_start_tach_controller_defines.svh */
// Assertion macros for the stirrer motor controller.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef MOTOR_SOFT_START_TACH_CONTROLLER_DEFINES_SVH
`define MOTOR_SOFT_START_TACH_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define MSSTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSSTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/msstc_pkg.sv */
// Shared types and constants for the stirrer motor controller.
// No dependencies.
package msstc_pkg;

    localparam int DIVIDEND_W = 30;
    localparam int DIVISOR_W  = 33;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_BUTTON = 2'd2,
        MODE_HALL   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_HOLD_TICKS  = 3'd0,
        REG_RAMP_DELAY  = 3'd1,
        REG_RAMP_STEP   = 3'd2,
        REG_START_DUTY  = 3'd3,
        REG_MIN_DUTY    = 3'd4,
        REG_MAX_SETPT   = 3'd5,
        REG_MIN_SETPT   = 3'd6,
        REG_SPEED_SCALE = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_SAMPLE,
        CMD_BUTTON,
        CMD_TICK_COUNT,
        CMD_MOD_START,
        CMD_RAMP_STEP,
        CMD_TRACK,
        CMD_HALL_NOW,
        CMD_HALL_SAT,
        CMD_DIV_START,
        CMD_HALL_FIN,
        CMD_OUT_LOAD
    } t_cmd;

    typedef struct packed {
        logic ramp_cand;
        logic period_zero;
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic [15:0] hold_ticks;
        logic [15:0] ramp_delay;
        logic [15:0] ramp_step;
        logic [6:0]  start_duty;
        logic [6:0]  min_duty;
        logic [12:0] max_setpt;
        logic [12:0] min_setpt;
        logic [29:0] speed_scale;
    } t_cfg;

endpackage

/* src/msstc_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Uses msstc_pkg widths.
module msstc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [msstc_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic [msstc_pkg::DIVISOR_W-1:0]     i_divisor,
    output logic [msstc_pkg::DIVIDEND_W-1:0]    o_quotient,
    output logic [msstc_pkg::DIVISOR_W-1:0]     o_remainder,
    output logic                                o_done
);
    localparam int CNT_W = $clog2(msstc_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(msstc_pkg::DIVIDEND_W - 1);

    logic [msstc_pkg::DIVISOR_W-1:0]  r_rem, n_rem;
    logic [msstc_pkg::DIVIDEND_W-1:0] r_quo, n_quo;
    logic [msstc_pkg::DIVISOR_W-1:0]  r_den;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_busy, r_done;
    logic [msstc_pkg::DIVISOR_W:0]    trial;

    always_comb begin
        trial = {r_rem, r_quo[msstc_pkg::DIVIDEND_W-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = msstc_pkg::DIVISOR_W'(trial - {1'b0, r_den});
            n_quo = {r_quo[msstc_pkg::DIVIDEND_W-2:0], 1'b1};
        end else begin
            n_rem = trial[msstc_pkg::DIVISOR_W-1:0];
            n_quo = {r_quo[msstc_pkg::DIVIDEND_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;
endmodule

/* src/msstc_dp.sv */
// Datapath: controller state, sample scaling, ramp, tachometer and result register.
// Uses msstc_pkg and msstc_div.
module msstc_dp #(
    parameter int TICK_US = 100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msstc_pkg::t_cmd   i_cmd,
    input  msstc_pkg::t_cfg   i_cfg,
    input  logic [11:0]       i_adc_value,
    input  logic [6:0]        i_sub_tick,
    output msstc_pkg::t_stat  o_stat,
    output logic [55:0]       o_result
);
    localparam int TU_W = $clog2(TICK_US + 1);
    localparam logic [TU_W-1:0] TICK_K = TU_W'(TICK_US);

    logic        r_holding, r_motor, r_ramping, r_tracking, r_cand;
    logic [15:0] r_phase, r_diff;
    logic [6:0]  r_ramp_duty, r_target, r_compare;
    logic [12:0] r_setpoint;
    logic [31:0] r_speed_ticks, r_last, r_speed, r_now;
    logic [11:0] r_adc;
    logic [6:0]  r_sub;
    logic [55:0] r_result;

    logic [15:0] ph1, ph2, step;
    logic        hold_clr;
    logic [18:0] duty_prod;
    logic [24:0] setpt_prod;
    logic [6:0]  duty_q;
    logic [12:0] setpt_q;
    logic [31:0] now_calc, diff32;
    logic [35:0] speed_prod;

    logic                                  div_start, div_done;
    logic [msstc_pkg::DIVIDEND_W-1:0]      div_num, div_quo;
    logic [msstc_pkg::DIVISOR_W-1:0]       div_den, div_rem;

    always_comb begin
        ph1      = r_holding ? r_phase + 16'd1 : r_phase;
        hold_clr = r_holding && (ph1 >= i_cfg.hold_ticks);
        if (hold_clr) begin
            ph1 = '0;
        end
        ph2  = ph1 + 16'd1;
        step = (i_cfg.ramp_step == '0) ? 16'd1 : i_cfg.ramp_step;

        duty_prod  = 19'(r_adc) * 19'd100;
        setpt_prod = 25'(r_adc) * 25'(i_cfg.max_setpt);
        duty_q  = duty_prod[18:12];
        setpt_q = setpt_prod[24:12];
        if (duty_q < i_cfg.min_duty) begin
            duty_q = i_cfg.min_duty;
        end
        if (setpt_q < i_cfg.min_setpt) begin
            setpt_q = i_cfg.min_setpt;
        end

        now_calc   = 32'(r_speed_ticks * 32'(TICK_K)) + 32'(r_sub);
        diff32     = r_now - r_last;
        speed_prod = 36'(div_quo) * 36'd60;

        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (i_cmd)
            msstc_pkg::CMD_MOD_START: begin
                div_start = 1'b1;
                div_num   = msstc_pkg::DIVIDEND_W'(r_diff);
                div_den   = msstc_pkg::DIVISOR_W'(step);
            end
            msstc_pkg::CMD_DIV_START: begin
                div_start = 1'b1;
                div_num   = i_cfg.speed_scale;
                div_den   = {diff32, 1'b0};
            end
            default: ;
        endcase
    end

    msstc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_num),
        .i_divisor   (div_den),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding     <= 1'b1;
            r_motor       <= 1'b0;
            r_ramping     <= 1'b0;
            r_tracking    <= 1'b0;
            r_cand        <= 1'b0;
            r_phase       <= '0;
            r_ramp_duty   <= '0;
            r_target      <= '0;
            r_compare     <= '0;
            r_setpoint    <= '0;
            r_speed_ticks <= '0;
            r_last        <= '0;
            r_speed       <= '0;
        end else begin
            case (i_cmd)
                msstc_pkg::CMD_SAMPLE: begin
                    if (!r_holding) begin
                        r_target   <= duty_q;
                        r_setpoint <= setpt_q;
                    end
                end
                msstc_pkg::CMD_BUTTON: begin
                    if (!r_holding) begin
                        if (r_motor) begin
                            r_motor       <= 1'b0;
                            r_ramping     <= 1'b0;
                            r_tracking    <= 1'b0;
                            r_compare     <= '0;
                            r_speed_ticks <= '0;
                            r_speed       <= '0;
                            r_last        <= '0;
                        end else begin
                            r_motor     <= 1'b1;
                            r_ramping   <= 1'b1;
                            r_phase     <= '0;
                            r_ramp_duty <= i_cfg.start_duty;
                            r_compare   <= i_cfg.start_duty;
                        end
                    end
                end
                msstc_pkg::CMD_TICK_COUNT: begin
                    if (hold_clr) begin
                        r_holding <= 1'b0;
                    end
                    r_cand <= r_ramping && (ph2 >= i_cfg.ramp_delay);
                    if (r_ramping) begin
                        r_phase       <= ph2;
                        r_speed_ticks <= r_speed_ticks + 32'd1;
                    end else begin
                        r_phase <= ph1;
                    end
                end
                msstc_pkg::CMD_RAMP_STEP: begin
                    // step point: remainder of (phase - delay) by step is zero
                    if (div_rem == '0) begin
                        if (r_ramp_duty <= r_target) begin
                            r_compare  <= r_target;
                            r_ramping  <= 1'b0;
                            r_tracking <= 1'b1;
                        end else begin
                            r_ramp_duty <= r_ramp_duty - 7'd1;
                            r_compare   <= r_ramp_duty - 7'd1;
                        end
                    end
                end
                msstc_pkg::CMD_TRACK: begin
                    if (r_tracking) begin
                        r_compare     <= r_target;
                        r_speed_ticks <= r_speed_ticks + 32'd1;
                    end
                end
                msstc_pkg::CMD_HALL_SAT: begin
                    r_speed <= '1;
                    r_last  <= r_now;
                end
                msstc_pkg::CMD_HALL_FIN: begin
                    r_speed <= (speed_prod[35:32] != '0) ? '1 : speed_prod[31:0];
                    r_last  <= r_now;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd == msstc_pkg::CMD_CAPTURE) begin
            r_adc <= i_adc_value;
            r_sub <= i_sub_tick;
        end
        if (i_cmd == msstc_pkg::CMD_TICK_COUNT) begin
            r_diff <= ph2 - i_cfg.ramp_delay;
        end
        if (i_cmd == msstc_pkg::CMD_HALL_NOW) begin
            r_now <= now_calc;
        end
        if (i_cmd == msstc_pkg::CMD_OUT_LOAD) begin
            r_result <= {2'b00, !r_holding, r_setpoint, r_speed, r_motor, r_compare};
        end
    end

    assign o_stat.ramp_cand   = r_cand;
    assign o_stat.period_zero = (diff32 == '0);
    assign o_stat.div_done    = div_done;
    assign o_result           = r_result;
endmodule

/* src/msstc_ctrl.sv */
// Sequencer: walks each event through the datapath and owns the result handshake.
// Uses msstc_pkg.
module msstc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  msstc_pkg::t_stat  i_stat,
    output msstc_pkg::t_cmd   o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_SAMPLE, S_BUTTON, S_TICK1, S_TICK2, S_MODWAIT, S_RAMP, S_TRACK,
        S_HALL1, S_HALL2, S_HALLWAIT, S_HALL3, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = msstc_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = msstc_pkg::CMD_CAPTURE;
                    case (msstc_pkg::t_mode'(i_mode))
                        msstc_pkg::MODE_TICK:   n_state = S_TICK1;
                        msstc_pkg::MODE_SAMPLE: n_state = S_SAMPLE;
                        msstc_pkg::MODE_BUTTON: n_state = S_BUTTON;
                        default:                n_state = S_HALL1;
                    endcase
                end
            end
            S_SAMPLE: begin
                o_cmd   = msstc_pkg::CMD_SAMPLE;
                n_state = S_OUT;
            end
            S_BUTTON: begin
                o_cmd   = msstc_pkg::CMD_BUTTON;
                n_state = S_OUT;
            end
            S_TICK1: begin
                o_cmd   = msstc_pkg::CMD_TICK_COUNT;
                n_state = S_TICK2;
            end
            S_TICK2: begin
                if (i_stat.ramp_cand) begin
                    o_cmd   = msstc_pkg::CMD_MOD_START;
                    n_state = S_MODWAIT;
                end else begin
                    n_state = S_TRACK;
                end
            end
            S_MODWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_RAMP;
                end
            end
            S_RAMP: begin
                o_cmd   = msstc_pkg::CMD_RAMP_STEP;
                n_state = S_TRACK;
            end
            S_TRACK: begin
                o_cmd   = msstc_pkg::CMD_TRACK;
                n_state = S_OUT;
            end
            S_HALL1: begin
                o_cmd   = msstc_pkg::CMD_HALL_NOW;
                n_state = S_HALL2;
            end
            S_HALL2: begin
                if (i_stat.period_zero) begin
                    o_cmd   = msstc_pkg::CMD_HALL_SAT;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = msstc_pkg::CMD_DIV_START;
                    n_state = S_HALLWAIT;
                end
            end
            S_HALLWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_HALL3;
                end
            end
            S_HALL3: begin
                o_cmd   = msstc_pkg::CMD_HALL_FIN;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd   = msstc_pkg::CMD_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd == msstc_pkg::CMD_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

/* src/motor_soft_start_tach_controller.sv */
// Stirrer motor controller driven by one event per request: tick, pot sample, button
// or hall edge, each giving one status result. Events are handled one at a time.
// Ticks run the serial divider when a ramp step point is checked, and hall edges run
// the same divider unless the interval is zero; samples and buttons do not. The result
// is valid as the block turns ready again; a new request is taken while it still waits.
// Depends on msstc_pkg, msstc_ctrl, msstc_dp, msstc_div and the defines header.
`include "motor_soft_start_tach_controller_defines.svh"

module motor_soft_start_tach_controller #(
    parameter int TICK_US = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // adc_value[11:0], sub_tick[18:12], zero pad
    input  logic [1:0]  i_s_axis_tuser,  // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pwm_duty[6:0], motor_on[7], speed_rpm[39:8], setpoint_rpm[52:40], ready_res[53]
    output logic [55:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    msstc_pkg::t_cfg  r_cfg;
    msstc_pkg::t_cmd  w_cmd;
    msstc_pkg::t_stat w_stat;
    msstc_pkg::t_reg  reg_sel;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = msstc_pkg::t_reg'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks  <= 16'd15000;
            r_cfg.ramp_delay  <= 16'd30000;
            r_cfg.ramp_step   <= 16'd300;
            r_cfg.start_duty  <= 7'd100;
            r_cfg.min_duty    <= 7'd10;
            r_cfg.max_setpt   <= 13'd6000;
            r_cfg.min_setpt   <= 13'd600;
            r_cfg.speed_scale <= 30'd1000000000;
        end else if (cfg_wr) begin
            case (reg_sel)
                msstc_pkg::REG_HOLD_TICKS:  r_cfg.hold_ticks  <= pwdata[15:0];
                msstc_pkg::REG_RAMP_DELAY:  r_cfg.ramp_delay  <= pwdata[15:0];
                msstc_pkg::REG_RAMP_STEP:   r_cfg.ramp_step   <= pwdata[15:0];
                msstc_pkg::REG_START_DUTY:  r_cfg.start_duty  <= pwdata[6:0];
                msstc_pkg::REG_MIN_DUTY:    r_cfg.min_duty    <= pwdata[6:0];
                msstc_pkg::REG_MAX_SETPT:   r_cfg.max_setpt   <= pwdata[12:0];
                msstc_pkg::REG_MIN_SETPT:   r_cfg.min_setpt   <= pwdata[12:0];
                default:                    r_cfg.speed_scale <= pwdata[29:0];
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            msstc_pkg::REG_HOLD_TICKS:  prdata = 32'(r_cfg.hold_ticks);
            msstc_pkg::REG_RAMP_DELAY:  prdata = 32'(r_cfg.ramp_delay);
            msstc_pkg::REG_RAMP_STEP:   prdata = 32'(r_cfg.ramp_step);
            msstc_pkg::REG_START_DUTY:  prdata = 32'(r_cfg.start_duty);
            msstc_pkg::REG_MIN_DUTY:    prdata = 32'(r_cfg.min_duty);
            msstc_pkg::REG_MAX_SETPT:   prdata = 32'(r_cfg.max_setpt);
            msstc_pkg::REG_MIN_SETPT:   prdata = 32'(r_cfg.min_setpt);
            default:                    prdata = 32'(r_cfg.speed_scale);
        endcase
    end

    msstc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_mode      (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    msstc_dp #(
        .TICK_US (TICK_US)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_adc_value (i_s_axis_tdata[11:0]),
        .i_sub_tick  (i_s_axis_tdata[18:12]),
        .o_stat      (w_stat),
        .o_result    (o_m_axis_tdata)
    );

    `MSSTC_ASSERT_NEXT(a_one_at_a_time, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "request taken while busy")
    `MSSTC_ASSERT_NOW(a_out_from_load, $rose(o_m_axis_tvalid), $past(w_cmd == msstc_pkg::CMD_OUT_LOAD), "result shown without load")
    `MSSTC_ASSERT_NOW(a_no_zero_divide, w_cmd == msstc_pkg::CMD_DIV_START, !w_stat.period_zero, "divide by zero period")
endmodule
